// ===== src/bar_meter_level_peak_hold_macros.svh =====
// Assertion macros used by the bar meter RTL.
`ifndef BAR_METER_LEVEL_PEAK_HOLD_MACROS_SVH
`define BAR_METER_LEVEL_PEAK_HOLD_MACROS_SVH

// Condition in the same cycle implies the consequence in the same cycle.
`define BMLPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition in one cycle implies the consequence in the next cycle.
`define BMLPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bmlph_pkg.sv =====
`timescale 1ns / 1ps

package bmlph_pkg;

  localparam int LEVEL_W  = 16;
  localparam int COL_W    = 6;
  localparam int TIMER_W  = 16;
  localparam int RATE_W   = 16;
  localparam int ROWS_W   = 6;
  localparam int PROW_W   = 5;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam int DEF_COLUMNS = 64;

  localparam logic [ROWS_W-1:0] MIN_ROWS = 6'd10;
  localparam logic [ROWS_W-1:0] MAX_ROWS = 6'd32;

  // Register indexes, byte address is 4 * index.
  localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HOLD    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROWS    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PEAK_EN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_THRESH  = 3'd6;

  localparam logic [RATE_W-1:0]  RST_ATTACK  = 16'd23593;
  localparam logic [RATE_W-1:0]  RST_RELEASE = 16'd8847;
  localparam logic [RATE_W-1:0]  RST_DECAY   = 16'd62259;
  localparam logic [TIMER_W-1:0] RST_HOLD    = 16'd500;
  localparam logic [ROWS_W-1:0]  RST_ROWS    = 6'd24;
  localparam logic               RST_PEAK_EN = 1'b1;
  localparam logic [LEVEL_W-1:0] RST_THRESH  = 16'd3277;

  // Per-column state held in the column memory.
  typedef struct packed {
    logic [LEVEL_W-1:0] smooth;
    logic [LEVEL_W-1:0] peak;
    logic [TIMER_W-1:0] timer;
  } state_t;

  // One result word.
  typedef struct packed {
    logic [COL_W-1:0]   out_column;
    logic [LEVEL_W-1:0] smoothed_level;
    logic [ROWS_W-1:0]  lit_count;
    logic [PROW_W-1:0]  peak_row;
    logic               peak_visible;
  } res_t;

endpackage

// ===== src/bmlph_if.sv =====
`timescale 1ns / 1ps

interface bmlph_in_if import bmlph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   column;
  logic [LEVEL_W-1:0] level;
  logic [TIMER_W-1:0] elapsed_ms;

  modport source (output valid, column, level, elapsed_ms, input ready);
  modport sink   (input valid, column, level, elapsed_ms, output ready);
endinterface

interface bmlph_out_if import bmlph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   out_column;
  logic [LEVEL_W-1:0] smoothed_level;
  logic [ROWS_W-1:0]  lit_count;
  logic [PROW_W-1:0]  peak_row;
  logic               peak_visible;

  modport source (output valid, out_column, smoothed_level, lit_count, peak_row,
                  peak_visible, input ready);
  modport sink   (input valid, out_column, smoothed_level, lit_count, peak_row,
                  peak_visible, output ready);
endinterface

// ===== src/bar_meter_level_peak_hold.sv =====
`timescale 1ns / 1ps
// An accepted input word passes through the pipeline stages and the output register.
// Throughput: one word per cycle while the skid stage is empty; a word for the
// same column as the word in stage 1 waits until that word moves on to stage 2.
// Reset: configuration registers return to their defaults, all column state reads as zero
// through per-column valid bits, so no clearing pass is needed.

module bar_meter_level_peak_hold import bmlph_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS
) (
  input  logic                clk,
  input  logic                rst_n,
  bmlph_in_if.sink            in_if,
  bmlph_out_if.source         out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

`include "bar_meter_level_peak_hold_macros.svh"

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int WRAP_W = 9;
  localparam int WRAP_STEPS = ((2 ** COL_W) - 1) / COLUMNS;
  localparam int PROD_W = LEVEL_W + ROWS_W;
  localparam int MUL_W = LEVEL_W + RATE_W;

  // ---------------- configuration registers ----------------
  logic [RATE_W-1:0]  attack_r, release_r, decay_r;
  logic [TIMER_W-1:0] hold_r;
  logic [ROWS_W-1:0]  rows_r;
  logic               peak_en_r;
  logic [LEVEL_W-1:0] thresh_r;
  logic               cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [ROWS_W-1:0]  rows_used;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= RST_ATTACK;
      release_r <= RST_RELEASE;
      decay_r   <= RST_DECAY;
      hold_r    <= RST_HOLD;
      rows_r    <= RST_ROWS;
      peak_en_r <= RST_PEAK_EN;
      thresh_r  <= RST_THRESH;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATTACK:  attack_r  <= pwdata[RATE_W-1:0];
        REG_RELEASE: release_r <= pwdata[RATE_W-1:0];
        REG_DECAY:   decay_r   <= pwdata[RATE_W-1:0];
        REG_HOLD:    hold_r    <= pwdata[TIMER_W-1:0];
        REG_ROWS:    rows_r    <= pwdata[ROWS_W-1:0];
        REG_PEAK_EN: peak_en_r <= pwdata[0];
        REG_THRESH:  thresh_r  <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ATTACK:  prdata = DATA_W'(attack_r);
      REG_RELEASE: prdata = DATA_W'(release_r);
      REG_DECAY:   prdata = DATA_W'(decay_r);
      REG_HOLD:    prdata = DATA_W'(hold_r);
      REG_ROWS:    prdata = DATA_W'(rows_r);
      REG_PEAK_EN: prdata = DATA_W'(peak_en_r);
      REG_THRESH:  prdata = DATA_W'(thresh_r);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    if (rows_r < MIN_ROWS) begin
      rows_used = MIN_ROWS;
    end else if (rows_r > MAX_ROWS) begin
      rows_used = MAX_ROWS;
    end else begin
      rows_used = rows_r;
    end
  end

  // ---------------- column wrap ----------------
  function automatic logic [CW-1:0] col_wrap(input logic [COL_W-1:0] col);
    logic [WRAP_W-1:0] rem;
    rem = WRAP_W'(col);
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (rem >= WRAP_W'(COLUMNS)) begin
        rem = rem - WRAP_W'(COLUMNS);
      end
    end
    return rem[CW-1:0];
  endfunction

  // ---------------- pipeline control ----------------
  logic          adv;
  logic          skid_vld_r;
  logic          out_vld_r;
  logic [CW-1:0] in_col_w;
  logic          hazard;
  logic          in_acc;

  logic               s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [CW-1:0]      s1_col_r, s2_col_r;
  logic [COL_W-1:0]   s1_colin_r, s2_colin_r, s3_colin_r, s4_colin_r;
  logic [LEVEL_W-1:0] s1_tgt_r;
  logic [TIMER_W-1:0] s1_ela_r, s2_ela_r;

  // The whole pipeline moves unless the skid stage is occupied.
  assign adv      = !skid_vld_r;
  assign in_col_w = col_wrap(in_if.column);
  // The word in stage 1 writes its column back only at the end of stage 2.
  assign hazard   = s1_vld_r && (s1_col_r == in_col_w);
  assign in_if.ready = adv && !hazard;
  assign in_acc   = in_if.valid && in_if.ready;

  // ---------------- column state memory ----------------
  state_t mem_rd;
  state_t st_nxt;
  logic   mem_we;

  assign mem_we = adv && s2_vld_r;

  bmlph_state_mem #(
    .COLUMNS (COLUMNS)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (s2_col_r),
    .wr_data (st_nxt),
    .rd_en   (adv),
    .rd_addr (in_col_w),
    .rd_data (mem_rd)
  );

  // ---------------- stage 1: gap times rate, peak times decay ----------------
  logic               s1_rise;
  logic [LEVEL_W-1:0] s1_gap;
  logic [RATE_W-1:0]  s1_rate;
  logic [MUL_W-1:0]   s1_step_prod;
  logic [MUL_W-1:0]   s1_dec_prod;

  assign s1_rise      = mem_rd.smooth < s1_tgt_r;
  assign s1_gap       = s1_rise ? (s1_tgt_r - mem_rd.smooth) : (mem_rd.smooth - s1_tgt_r);
  assign s1_rate      = s1_rise ? attack_r : release_r;
  assign s1_step_prod = MUL_W'(s1_gap) * MUL_W'(s1_rate);
  assign s1_dec_prod  = MUL_W'(mem_rd.peak) * MUL_W'(decay_r);

  logic               s2_rise_r;
  logic [LEVEL_W-1:0] s2_cur_r, s2_peak_r, s2_step_r, s2_dec_r;
  logic [TIMER_W-1:0] s2_tmr_r;

  // ---------------- stage 2: new level, peak and timer ----------------
  logic [LEVEL_W-1:0] s2_next;

  assign s2_next = s2_rise_r ? (s2_cur_r + s2_step_r) : (s2_cur_r - s2_step_r);

  always_comb begin
    st_nxt.smooth = s2_next;
    st_nxt.peak   = s2_peak_r;
    st_nxt.timer  = s2_tmr_r;
    if (peak_en_r) begin
      if (s2_next >= s2_peak_r) begin
        st_nxt.peak  = s2_next;
        st_nxt.timer = hold_r;
      end else if (s2_tmr_r != '0) begin
        st_nxt.timer = (s2_tmr_r > s2_ela_r) ? (s2_tmr_r - s2_ela_r) : '0;
      end else begin
        st_nxt.peak = s2_dec_r;
      end
    end
  end

  logic [LEVEL_W-1:0] s3_next_r, s3_peak_r;
  logic               s3_tnz_r;

  // ---------------- stage 3: scale level and peak to rows ----------------
  logic [PROD_W-1:0] s3_lit_prod, s3_pk_prod;

  assign s3_lit_prod = PROD_W'(s3_next_r) * PROD_W'(rows_used);
  assign s3_pk_prod  = PROD_W'(s3_peak_r) * PROD_W'(rows_used);

  logic [LEVEL_W-1:0] s4_next_r;
  logic [ROWS_W-1:0]  s4_lit_r, s4_pk_r;
  logic               s4_tnz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_acc;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col_r   <= in_col_w;
      s1_colin_r <= in_if.column;
      s1_tgt_r   <= in_if.level;
      s1_ela_r   <= in_if.elapsed_ms;

      s2_col_r   <= s1_col_r;
      s2_colin_r <= s1_colin_r;
      s2_ela_r   <= s1_ela_r;
      s2_rise_r  <= s1_rise;
      s2_cur_r   <= mem_rd.smooth;
      s2_peak_r  <= mem_rd.peak;
      s2_tmr_r   <= mem_rd.timer;
      s2_step_r  <= s1_step_prod[MUL_W-1:RATE_W];
      s2_dec_r   <= s1_dec_prod[MUL_W-1:RATE_W];

      s3_colin_r <= s2_colin_r;
      s3_next_r  <= st_nxt.smooth;
      s3_peak_r  <= st_nxt.peak;
      s3_tnz_r   <= (st_nxt.timer != '0);

      s4_colin_r <= s3_colin_r;
      s4_next_r  <= s3_next_r;
      s4_lit_r   <= s3_lit_prod[PROD_W-1:LEVEL_W];
      s4_pk_r    <= s3_pk_prod[PROD_W-1:LEVEL_W];
      s4_tnz_r   <= s3_tnz_r;
    end
  end

  // ---------------- stage 4: LED count and peak marker ----------------
  res_t              s4_res;
  logic [ROWS_W-1:0] s4_lit;
  logic [ROWS_W-1:0] s4_pk_m1;
  logic              s4_vis;

  assign s4_pk_m1 = s4_pk_r - ROWS_W'(1);

  always_comb begin
    s4_lit = s4_lit_r;
    if ((s4_lit_r == '0) && (s4_next_r > thresh_r)) begin
      s4_lit = ROWS_W'(1);
    end
    if (s4_lit > rows_used) begin
      s4_lit = rows_used;
    end
  end

  assign s4_vis = peak_en_r && s4_tnz_r && (s4_pk_r != '0) && (s4_pk_m1 < rows_used);

  always_comb begin
    s4_res.out_column     = s4_colin_r;
    s4_res.smoothed_level = s4_next_r;
    s4_res.lit_count      = s4_lit;
    s4_res.peak_row       = s4_vis ? s4_pk_m1[PROW_W-1:0] : '0;
    s4_res.peak_visible   = s4_vis;
  end

  // ---------------- output register with skid stage ----------------
  res_t out_r, skid_r;
  logic push;

  assign push = adv && s4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_if.ready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_if.ready) begin
      out_r <= skid_vld_r ? skid_r : s4_res;
    end else if (push) begin
      skid_r <= s4_res;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.out_column     = out_r.out_column;
  assign out_if.smoothed_level = out_r.smoothed_level;
  assign out_if.lit_count      = out_r.lit_count;
  assign out_if.peak_row       = out_r.peak_row;
  assign out_if.peak_visible   = out_r.peak_visible;

  // ---------------- assertions ----------------
  `BMLPH_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_vld_r, out_vld_r, "skid word without output word")
  `BMLPH_ASSERT_NOW(a_no_rmw_overlap, clk, rst_n, s1_vld_r && s2_vld_r, s1_col_r != s2_col_r, "same column in stages 1 and 2")
  `BMLPH_ASSERT_NEXT(a_accept_clears_hazard, clk, rst_n, in_acc && adv, !(s2_vld_r && s1_vld_r && (s1_col_r == s2_col_r)), "accepted word overlaps write-back")
  `BMLPH_ASSERT_NOW(a_lit_in_range, clk, rst_n, out_vld_r, (out_r.lit_count <= rows_used) && (!out_r.peak_visible || peak_en_r), "lit count or marker out of range")

endmodule

// ===== src/bmlph_state_mem.sv =====
`timescale 1ns / 1ps

module bmlph_state_mem import bmlph_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [CW-1:0] wr_addr,
  input  state_t        wr_data,
  input  logic          rd_en,
  input  logic [CW-1:0] rd_addr,
  output state_t        rd_data
);

  state_t               mem_r [COLUMNS];
  logic [COLUMNS-1:0]   vld_r;
  state_t               rd_q_r;
  logic                 rd_vld_r;
  logic                 wr_hit;

  // A read at the same edge as a write to the same entry returns the new data.
  assign wr_hit = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= wr_hit ? wr_data : mem_r[rd_addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= wr_hit || vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
